// ===== hdl/cholesky_3x3_factor_defines.svh =====
// ----------------------------------------------------------------------------
// cholesky_3x3_factor_defines
// assertion macros shared by the factor block
// ----------------------------------------------------------------------------
`ifndef CHOLESKY_3X3_FACTOR_DEFINES_SVH
`define CHOLESKY_3X3_FACTOR_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define CHOL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define CHOL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chol_pkg.sv =====
// ----------------------------------------------------------------------------
// chol_pkg
// widths, stage map, cell payload types and helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package chol_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = (33 + FRAC_BITS) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QUO_W     = 32;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = QUO_W;

  // stage map
  localparam int A0  = 0;
  localparam int B0  = A0 + SQ_STEPS;
  localparam int F1  = B0 + DIV_STEPS;
  localparam int P1  = F1 + 1;
  localparam int S1  = P1 + 1;
  localparam int C0  = S1 + 1;
  localparam int D0  = C0 + SQ_STEPS;
  localparam int F2  = D0 + DIV_STEPS;
  localparam int P2  = F2 + 1;
  localparam int S2  = P2 + 1;
  localparam int E0  = S2 + 1;
  localparam int NST = E0 + SQ_STEPS;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [31:0]        Q_MIN_MAG = 32'h8000_0000;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [QUO_W-1:0]  num;
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] den;
    logic [QUO_W-1:0]  q;
  } div_t;

  typedef struct packed {
    div_t d;
    logic neg;
    logic sat;
  } div_prep_t;

  typedef struct packed {
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic               ok;
    logic               neg0;
    logic               sat0;
    logic               neg1;
    logic               sat1;
    logic [ROOT_W-1:0]  l00;
    logic [ROOT_W-1:0]  l11;
    logic signed [31:0] l10;
    logic signed [31:0] l20;
    logic signed [31:0] l21;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] pc;
    logic signed [63:0] num21;
    logic signed [63:0] m20;
    logic [30:0]        rt;
  } ctx_t;

  function automatic sqrt_t sqrt_prep(input logic [30:0] r);
    sqrt_t s;
    s.rad  = RAD_W'(r) << FRAC_BITS;
    s.rem  = '0;
    s.root = '0;
    return s;
  endfunction

  function automatic div_prep_t div_prep(input logic signed [63:0] s,
                                         input logic [ROOT_W-1:0] den);
    logic [63:0] mag;
    logic [63:0] n;
    logic [31:0] hi;
    div_prep_t   p;
    mag      = s[63] ? (~s + 64'd1) : s;
    n        = mag << FRAC_BITS;
    hi       = n[63:32];
    p.neg    = s[63];
    p.sat    = ((mag >> (63 - FRAC_BITS)) != 64'd0) || (hi >= 32'(den));
    p.d.num  = n[31:0];
    p.d.rem  = hi[ROOT_W-1:0];
    p.d.den  = den;
    p.d.q    = '0;
    return p;
  endfunction

  function automatic logic signed [31:0] div_finish(input logic [31:0] q,
                                                    input logic neg,
                                                    input logic sat);
    logic signed [31:0] r;
    if (neg) begin
      r = (sat || q > Q_MIN_MAG) ? Q_MIN : (32'd0 - q);
    end else begin
      r = (sat || q[31]) ? Q_MAX : q;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cholesky_3x3_factor.sv =====
// ----------------------------------------------------------------------------
// cholesky_3x3_factor
// pipelined Cholesky factor of a symmetric 3x3 Q16.16 matrix
// ----------------------------------------------------------------------------
// Usage: present the lower triangle a00..a22 with a_valid; a transfer
// happens on a clock edge with a_valid high and a_stall low. The factor
// l00..l22 and positive_definite come out with l_valid; a transfer
// happens with l_valid high and l_stall low.
// One matrix is taken every cycle while the output is not stalled:
// each square root is a chain of ROOT_W digit cells, each division a
// chain of 32 quotient cells, and every cell hands its partial result on
// in each cycle.
// When the output register holds a result and l_stall is high, the whole
// chain freezes and a_stall goes high until that result is taken.
// Synchronous reset empties the chain and the output register; no
// clearing pass is needed.
// A non positive definite matrix gives all factor fields zero and
// positive_definite low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cholesky_3x3_factor_defines.svh"

module cholesky_3x3_factor import chol_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               a_valid,
  output logic               a_stall,
  input  logic signed [31:0] a00,
  input  logic signed [31:0] a10,
  input  logic signed [31:0] a11,
  input  logic signed [31:0] a20,
  input  logic signed [31:0] a21,
  input  logic signed [31:0] a22,
  output logic               l_valid,
  input  logic               l_stall,
  output logic [30:0]        l00,
  output logic signed [31:0] l10,
  output logic [30:0]        l11,
  output logic signed [31:0] l20,
  output logic signed [31:0] l21,
  output logic [30:0]        l22,
  output logic               positive_definite
);

  logic             adv;
  logic [NST-1:0]   vld;
  ctx_t             ctx [NST];
  ctx_t             ctx_a, ctx_b, ctx_f1, ctx_p1, ctx_s1;
  ctx_t             ctx_d, ctx_f2, ctx_p2, ctx_s2;
  div_prep_t        pb0, pb1, pd;
  logic signed [63:0] d1, d2;

  sqrt_t sqa_i [SQ_STEPS], sqa_o [SQ_STEPS];
  sqrt_t sqc_i [SQ_STEPS], sqc_o [SQ_STEPS];
  sqrt_t sqe_i [SQ_STEPS], sqe_o [SQ_STEPS];
  div_t  db0_i [DIV_STEPS], db0_o [DIV_STEPS];
  div_t  db1_i [DIV_STEPS], db1_o [DIV_STEPS];
  div_t  dd_i  [DIV_STEPS], dd_o  [DIV_STEPS];

  assign adv     = !(l_valid && l_stall);
  assign a_stall = !adv;

  // stage entry context
  always_comb begin
    ctx_a     = '0;
    ctx_a.a10 = a10;
    ctx_a.a11 = a11;
    ctx_a.a20 = a20;
    ctx_a.a21 = a21;
    ctx_a.a22 = a22;
    ctx_a.ok  = !a00[31] && (a00 != 32'sd0);

    pb0        = div_prep({{32{ctx[B0-1].a10[31]}}, ctx[B0-1].a10}, sqa_o[SQ_STEPS-1].root);
    pb1        = div_prep({{32{ctx[B0-1].a20[31]}}, ctx[B0-1].a20}, sqa_o[SQ_STEPS-1].root);
    ctx_b      = ctx[B0-1];
    ctx_b.l00  = sqa_o[SQ_STEPS-1].root;
    ctx_b.neg0 = pb0.neg;
    ctx_b.sat0 = pb0.sat;
    ctx_b.neg1 = pb1.neg;
    ctx_b.sat1 = pb1.sat;

    ctx_f1     = ctx[F1-1];
    ctx_f1.l10 = div_finish(db0_o[DIV_STEPS-1].q, ctx[F1-1].neg0, ctx[F1-1].sat0);
    ctx_f1.l20 = div_finish(db1_o[DIV_STEPS-1].q, ctx[F1-1].neg1, ctx[F1-1].sat1);

    ctx_p1     = ctx[P1-1];
    ctx_p1.pa  = ctx[P1-1].l10 * ctx[P1-1].l10;
    ctx_p1.pb  = ctx[P1-1].l20 * ctx[P1-1].l10;
    ctx_p1.pc  = ctx[P1-1].l20 * ctx[P1-1].l20;

    d1           = $signed({{32{ctx[S1-1].a11[31]}}, ctx[S1-1].a11})
                   - (ctx[S1-1].pa >>> FRAC_BITS);
    ctx_s1       = ctx[S1-1];
    ctx_s1.ok    = ctx[S1-1].ok && !d1[63] && (d1 != 64'sd0);
    ctx_s1.rt    = d1[30:0];
    ctx_s1.num21 = $signed({{32{ctx[S1-1].a21[31]}}, ctx[S1-1].a21})
                   - (ctx[S1-1].pb >>> FRAC_BITS);
    ctx_s1.m20   = ctx[S1-1].pc >>> FRAC_BITS;

    pd         = div_prep(ctx[D0-1].num21, sqc_o[SQ_STEPS-1].root);
    ctx_d      = ctx[D0-1];
    ctx_d.l11  = sqc_o[SQ_STEPS-1].root;
    ctx_d.neg1 = pd.neg;
    ctx_d.sat1 = pd.sat;

    ctx_f2     = ctx[F2-1];
    ctx_f2.l21 = div_finish(dd_o[DIV_STEPS-1].q, ctx[F2-1].neg1, ctx[F2-1].sat1);

    ctx_p2     = ctx[P2-1];
    ctx_p2.pa  = ctx[P2-1].l21 * ctx[P2-1].l21;

    d2        = $signed({{32{ctx[S2-1].a22[31]}}, ctx[S2-1].a22}) - ctx[S2-1].m20
                - (ctx[S2-1].pa >>> FRAC_BITS);
    ctx_s2    = ctx[S2-1];
    ctx_s2.ok = ctx[S2-1].ok && !d2[63] && (d2 != 64'sd0);
    ctx_s2.rt = d2[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i < NST; i++) begin
        if (i != B0 && i != F1 && i != P1 && i != S1 &&
            i != D0 && i != F2 && i != P2 && i != S2) begin
          ctx[i] <= ctx[i-1];
        end
      end
      ctx[A0] <= ctx_a;
      ctx[B0] <= ctx_b;
      ctx[F1] <= ctx_f1;
      ctx[P1] <= ctx_p1;
      ctx[S1] <= ctx_s1;
      ctx[D0] <= ctx_d;
      ctx[F2] <= ctx_f2;
      ctx[P2] <= ctx_p2;
      ctx[S2] <= ctx_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], a_valid};
    end
  end

  // square root chains
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    if (k == 0) begin : g_head
      assign sqa_i[k] = sqrt_prep(a00[30:0]);
      assign sqc_i[k] = sqrt_prep(ctx[C0-1].rt);
      assign sqe_i[k] = sqrt_prep(ctx[E0-1].rt);
    end else begin : g_link
      assign sqa_i[k] = sqa_o[k-1];
      assign sqc_i[k] = sqc_o[k-1];
      assign sqe_i[k] = sqe_o[k-1];
    end
    chol_sqrt_cell u_sqa (.clk(clk), .en(adv), .din(sqa_i[k]), .dout(sqa_o[k]));
    chol_sqrt_cell u_sqc (.clk(clk), .en(adv), .din(sqc_i[k]), .dout(sqc_o[k]));
    chol_sqrt_cell u_sqe (.clk(clk), .en(adv), .din(sqe_i[k]), .dout(sqe_o[k]));
  end

  // division chains
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    if (k == 0) begin : g_head
      assign db0_i[k] = pb0.d;
      assign db1_i[k] = pb1.d;
      assign dd_i[k]  = pd.d;
    end else begin : g_link
      assign db0_i[k] = db0_o[k-1];
      assign db1_i[k] = db1_o[k-1];
      assign dd_i[k]  = dd_o[k-1];
    end
    chol_div_cell u_db0 (.clk(clk), .en(adv), .din(db0_i[k]), .dout(db0_o[k]));
    chol_div_cell u_db1 (.clk(clk), .en(adv), .din(db1_i[k]), .dout(db1_o[k]));
    chol_div_cell u_dd  (.clk(clk), .en(adv), .din(dd_i[k]),  .dout(dd_o[k]));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (adv) begin
      l_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      positive_definite <= ctx[NST-1].ok;
      l00 <= ctx[NST-1].ok ? 31'(ctx[NST-1].l00) : 31'd0;
      l11 <= ctx[NST-1].ok ? 31'(ctx[NST-1].l11) : 31'd0;
      l22 <= ctx[NST-1].ok ? 31'(sqe_o[SQ_STEPS-1].root) : 31'd0;
      l10 <= ctx[NST-1].ok ? ctx[NST-1].l10 : 32'sd0;
      l20 <= ctx[NST-1].ok ? ctx[NST-1].l20 : 32'sd0;
      l21 <= ctx[NST-1].ok ? ctx[NST-1].l21 : 32'sd0;
    end
  end

  `CHOL_ASSERT_IMP(a_fail_zero, l_valid && !positive_definite, l00 == 31'd0 && l11 == 31'd0 && l22 == 31'd0 && l10 == 32'sd0 && l20 == 32'sd0 && l21 == 32'sd0, "failed factor not zero")
  `CHOL_ASSERT_IMP(a_diag_nonzero, l_valid && positive_definite, l00 != 31'd0 && l11 != 31'd0 && l22 != 31'd0, "zero diagonal on success")
  `CHOL_ASSERT_NXT(a_chain_hold, a_stall, $stable(vld), "chain moved while stalled")

endmodule

`default_nettype wire

// ===== hdl/chol_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// chol_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
`default_nettype none

module chol_sqrt_cell import chol_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;
  sqrt_t            dout_next;

  always_comb begin
    rem_sh         = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
    trial          = {din.root, 2'b01};
    diff           = rem_sh - trial;
    ge             = rem_sh >= trial;
    dout_next.rad  = {din.rad[RAD_W-3:0], 2'b00};
    dout_next.root = {din.root[ROOT_W-2:0], ge};
    dout_next.rem  = ge ? diff : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chol_div_cell.sv =====
// ----------------------------------------------------------------------------
// chol_div_cell
// one quotient bit of restoring division, registered
// ----------------------------------------------------------------------------
`default_nettype none

module chol_div_cell import chol_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  logic [ROOT_W:0] rem_sh;
  logic [ROOT_W:0] diff;
  logic            ge;
  div_t            dout_next;

  always_comb begin
    rem_sh        = {din.rem, din.num[QUO_W-1]};
    diff          = rem_sh - {1'b0, din.den};
    ge            = rem_sh >= {1'b0, din.den};
    dout_next.num = {din.num[QUO_W-2:0], 1'b0};
    dout_next.rem = ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
    dout_next.den = din.den;
    dout_next.q   = {din.q[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire
